[rtl/core/gfli_pkg.sv]
// Shared types and constants of the gap fill linear interpolator.
// Used by gfli_divider and gap_fill_linear_interpolator; depends on nothing.
package gfli_pkg;

    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 24;
    localparam int PERIOD_W   = 24;
    localparam int DIV_NUM_W  = 34;
    localparam int DIV_DEN_W  = 25;
    localparam int DIV_STEP_W = 6;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS,
        S_CNT_GO,
        S_CNT_WAIT,
        S_GAP_GO,
        S_GAP_WAIT,
        S_VAL_GO,
        S_VAL_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

[rtl/core/gfli_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on gfli_pkg for widths and the request and response structs.
module gfli_divider
    import gfli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [DIV_DEN_W-1:0] i_divisor,
    output t_div_rsp             o_rsp,
    output logic [DIV_NUM_W-1:0] o_quotient,
    output logic [DIV_DEN_W-1:0] o_remainder
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0]  r_num;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_NUM_W-1:0]  r_quo;

    logic [DIV_DEN_W:0]    w_trial;
    logic [DIV_DEN_W:0]    w_sub;
    logic                  w_ge;
    logic [DIV_DEN_W-1:0]  n_rem;

    // The dividend is left aligned; its top bit enters the partial remainder each step.
    always_comb begin
        w_trial = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_sub   = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_sub[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_STEP_W'(1);
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/core/gap_fill_linear_interpolator.sv]
// A stale sample is dropped as it is taken; the first sample after reset passes straight
// through. Any other sample runs a count division and ends there if its gap rounds to no
// point; else gap and value divisions follow on the shared bit-serial divider (34, 32 and
// 24 steps), then 1..MAX_FILL points leave, one per cycle while the output side takes them.
// One sample is in work at a time; the input is ready only between samples.
// Reset (synchronous, active low) clears the reference and sets gap_period to 1000.
module gap_fill_linear_interpolator
    import gfli_pkg::*;
#(
    parameter int MAX_FILL = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write channel, always ready.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [PERIOD_W-1:0]        i_cfg_data,
    // Sample input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [TIME_W-1:0]          i_sample_time,
    input  logic signed [VALUE_W-1:0]  i_sample_value,
    // Point output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [TIME_W-1:0]          o_out_time,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic                       o_last_of_run
);

    // Width of a point count, which runs from 1 up to MAX_FILL.
    localparam int CW = $clog2(MAX_FILL + 1);

    // Control state.
    t_state               r_state, n_state;
    logic                 r_have_ref, n_have_ref;
    logic [TIME_W-1:0]    r_ref_time, n_ref_time;
    logic [VALUE_W-1:0]   r_ref_value, n_ref_value;
    logic [PERIOD_W-1:0]  r_gap_period;
    logic                 r_out_valid, n_out_valid;

    // Payload and working registers.
    logic [TIME_W-1:0]    r_smp_time, n_smp_time;
    logic [VALUE_W-1:0]   r_smp_value, n_smp_value;
    logic [TIME_W-1:0]    r_gap, n_gap;
    logic                 r_neg, n_neg;
    logic [VALUE_W-1:0]   r_mag, n_mag;
    logic [CW-1:0]        r_count, n_count;
    logic [TIME_W-1:0]    r_qg, n_qg;
    logic [CW-1:0]        r_rg, n_rg;
    logic [VALUE_W-1:0]   r_qd, n_qd;
    logic [CW-1:0]        r_rd, n_rd;
    logic [TIME_W-1:0]    r_acc_t, n_acc_t;
    logic [CW-1:0]        r_acc_tr, n_acc_tr;
    logic [VALUE_W-1:0]   r_acc_v, n_acc_v;
    logic [CW-1:0]        r_acc_vr, n_acc_vr;
    logic [CW-1:0]        r_idx, n_idx;
    logic [TIME_W-1:0]    r_out_time, n_out_time;
    logic [VALUE_W-1:0]   r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;

    // Divider interface.
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [DIV_DEN_W-1:0] w_rem;

    // Helpers.
    logic                 w_out_free;
    logic [PERIOD_W-1:0]  w_period;
    logic [VALUE_W:0]     w_diff;
    logic [VALUE_W:0]     w_neg_diff;
    logic [CW:0]          w_tr_sum, w_tr_sub;
    logic [CW:0]          w_vr_sum, w_vr_sub;
    logic                 w_t_carry, w_v_carry;
    logic [VALUE_W-1:0]   w_v_step;
    logic [CW-1:0]        w_idx_inc;

    gfli_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_div_req),
        .i_dividend  (w_div_num),
        .i_divisor   (w_div_den),
        .o_rsp       (w_div_rsp),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // A period of zero behaves as a period of one tick.
    assign w_period = (r_gap_period == '0) ? PERIOD_W'(1) : r_gap_period;

    // The output register can take a new point when empty or when its point leaves now.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Value difference to the reference, split into sign and magnitude so that the
    // interpolated step truncates toward zero.
    always_comb begin
        w_diff     = {r_smp_value[VALUE_W-1], r_smp_value}
                   - {r_ref_value[VALUE_W-1], r_ref_value};
        w_neg_diff = '0 - w_diff;
    end

    // Point i sits at floor(gap * i / count) past the reference. Instead of a division
    // per point, the quotient and remainder of gap / count are accumulated, and a
    // remainder overflow carries one tick into the quotient. The value works the same
    // way on the magnitude of the difference.
    always_comb begin
        w_tr_sum  = {1'b0, r_acc_tr} + {1'b0, r_rg};
        w_tr_sub  = w_tr_sum - {1'b0, r_count};
        w_t_carry = (w_tr_sum >= {1'b0, r_count});
        w_vr_sum  = {1'b0, r_acc_vr} + {1'b0, r_rd};
        w_vr_sub  = w_vr_sum - {1'b0, r_count};
        w_v_carry = (w_vr_sum >= {1'b0, r_count});
        w_v_step  = r_qd + VALUE_W'(w_v_carry);
        w_idx_inc = r_idx + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_ref   <= 1'b0;
            r_ref_time   <= '0;
            r_ref_value  <= '0;
            r_gap_period <= PERIOD_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_ref  <= n_have_ref;
            r_ref_time  <= n_ref_time;
            r_ref_value <= n_ref_value;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gap_period <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp_time  <= n_smp_time;
        r_smp_value <= n_smp_value;
        r_gap       <= n_gap;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_count     <= n_count;
        r_qg        <= n_qg;
        r_rg        <= n_rg;
        r_qd        <= n_qd;
        r_rd        <= n_rd;
        r_acc_t     <= n_acc_t;
        r_acc_tr    <= n_acc_tr;
        r_acc_v     <= n_acc_v;
        r_acc_vr    <= n_acc_vr;
        r_idx       <= n_idx;
        r_out_time  <= n_out_time;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // Sequencer: count division, gap division, value division, then point emission.
    always_comb begin
        n_state     = r_state;
        n_have_ref  = r_have_ref;
        n_ref_time  = r_ref_time;
        n_ref_value = r_ref_value;
        n_out_valid = r_out_valid && !i_out_ready;
        n_smp_time  = r_smp_time;
        n_smp_value = r_smp_value;
        n_gap       = r_gap;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_count     = r_count;
        n_qg        = r_qg;
        n_rg        = r_rg;
        n_qd        = r_qd;
        n_rd        = r_rd;
        n_acc_t     = r_acc_t;
        n_acc_tr    = r_acc_tr;
        n_acc_v     = r_acc_v;
        n_acc_vr    = r_acc_vr;
        n_idx       = r_idx;
        n_out_time  = r_out_time;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        o_in_ready      = 1'b0;
        w_div_req.start = 1'b0;
        w_div_req.steps = '0;
        w_div_num       = '0;
        w_div_den       = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_smp_time  = i_sample_time;
                    n_smp_value = i_sample_value;
                    n_gap       = i_sample_time - r_ref_time;
                    if (!r_have_ref) begin
                        n_state = S_PASS;
                    end else if (i_sample_time > r_ref_time) begin
                        n_state = S_CNT_GO;
                    end
                end
            end
            S_PASS: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = r_smp_time;
                    n_out_value = r_smp_value;
                    n_out_last  = 1'b1;
                    n_have_ref  = 1'b1;
                    n_ref_time  = r_smp_time;
                    n_ref_value = r_smp_value;
                    n_state     = S_IDLE;
                end
            end
            S_CNT_GO: begin
                // count = floor((2 * gap + period) / (2 * period))
                w_div_req.start = 1'b1;
                w_div_req.steps = DIV_STEP_W'(DIV_NUM_W);
                w_div_num = DIV_NUM_W'({r_gap, 1'b0}) + DIV_NUM_W'(w_period);
                w_div_den = {w_period, 1'b0};
                n_neg     = w_diff[VALUE_W];
                n_mag     = w_diff[VALUE_W] ? w_neg_diff[VALUE_W-1:0]
                                            : w_diff[VALUE_W-1:0];
                n_state   = S_CNT_WAIT;
            end
            S_CNT_WAIT: begin
                if (w_div_rsp.done) begin
                    if (w_quo == '0) begin
                        // Gap rounds to no points: the reference stays.
                        n_state = S_IDLE;
                    end else begin
                        n_count = (w_quo > DIV_NUM_W'(MAX_FILL)) ? CW'(MAX_FILL)
                                                                 : w_quo[CW-1:0];
                        n_state = S_GAP_GO;
                    end
                end
            end
            S_GAP_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.steps = DIV_STEP_W'(TIME_W);
                w_div_num = {r_gap, {(DIV_NUM_W - TIME_W){1'b0}}};
                w_div_den = DIV_DEN_W'(r_count);
                n_state   = S_GAP_WAIT;
            end
            S_GAP_WAIT: begin
                if (w_div_rsp.done) begin
                    n_qg    = w_quo[TIME_W-1:0];
                    n_rg    = w_rem[CW-1:0];
                    n_state = S_VAL_GO;
                end
            end
            S_VAL_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.steps = DIV_STEP_W'(VALUE_W);
                w_div_num = {r_mag, {(DIV_NUM_W - VALUE_W){1'b0}}};
                w_div_den = DIV_DEN_W'(r_count);
                n_state   = S_VAL_WAIT;
            end
            S_VAL_WAIT: begin
                if (w_div_rsp.done) begin
                    n_qd     = w_quo[VALUE_W-1:0];
                    n_rd     = w_rem[CW-1:0];
                    n_acc_t  = r_ref_time;
                    n_acc_tr = '0;
                    n_acc_v  = r_ref_value;
                    n_acc_vr = '0;
                    n_idx    = '0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_acc_t  = r_acc_t + r_qg + TIME_W'(w_t_carry);
                    n_acc_tr = w_t_carry ? w_tr_sub[CW-1:0] : w_tr_sum[CW-1:0];
                    n_acc_v  = r_neg ? (r_acc_v - w_v_step) : (r_acc_v + w_v_step);
                    n_acc_vr = w_v_carry ? w_vr_sub[CW-1:0] : w_vr_sum[CW-1:0];
                    n_idx    = w_idx_inc;

                    n_out_valid = 1'b1;
                    n_out_time  = n_acc_t;
                    n_out_value = n_acc_v;
                    n_out_last  = (w_idx_inc == r_count);

                    // The final point lands on the sample, which becomes the reference.
                    if (w_idx_inc == r_count) begin
                        n_ref_time  = r_smp_time;
                        n_ref_value = r_smp_value;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_time    = r_out_time;
    assign o_out_value   = r_out_value;
    assign o_last_of_run = r_out_last;

endmodule
